FILE: rtl/mhbl_pkg.sv
// ----------------------------------------------------------------------------
// mhbl_pkg
// Shared types and constants of the minimum hop counter.
// ----------------------------------------------------------------------------
package mhbl_pkg;

  localparam int unsigned MAX_POINTS = 1024;
  localparam int unsigned MAX_LEVELS = 11;
  localparam int unsigned POS_WIDTH  = 32;

  localparam int unsigned COUNT_W = 11;
  localparam int unsigned REACH_W = 32;
  localparam int unsigned INDEX_W = 11;
  localparam int unsigned HOP_W   = 10;
  localparam int unsigned CFG_W   = 1;

  localparam logic [HOP_W-1:0]   HOP_MAX           = 10'd1023;
  localparam logic [COUNT_W-1:0] POINT_COUNT_RESET = 11'd2;
  localparam logic [REACH_W-1:0] REACH_RESET       = 32'd1;

  localparam logic [CFG_W-1:0] CFG_POINT_COUNT = 1'b0;
  localparam logic [CFG_W-1:0] CFG_REACH_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_BUILD = 2'd1,
    MODE_QUERY = 2'd2
  } mode_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SW_A,
    S_SW_B,
    S_SW_C,
    S_FILL,
    S_DBL_A,
    S_DBL_B,
    S_DBL_C,
    S_Q_WALK,
    S_Q_OUT
  } state_e;

endpackage

FILE: rtl/min_hops_binary_lifting.sv
// ----------------------------------------------------------------------------
// min_hops_binary_lifting
// Load: writes the position of one point. Build: sweeps with S_SW_B and S_SW_C
// per reach step and S_SW_A, S_SW_B and S_SW_C per start step, fills the slots
// from the last start, then doubles each table entry per level (S_DBL_A/B/C).
// Query: walks the levels from the top down, then outputs the result; a new item
// is taken only once idle again. Reset clears control and config registers, no memory pass.
// ----------------------------------------------------------------------------
module min_hops_binary_lifting #(
  parameter int unsigned MAX_POINTS = mhbl_pkg::MAX_POINTS,
  parameter int unsigned MAX_LEVELS = mhbl_pkg::MAX_LEVELS,
  parameter int unsigned POS_WIDTH  = mhbl_pkg::POS_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mhbl_pkg::CFG_W-1:0]    cfg_index_i,
  input  logic [31:0]                   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    mode_i,
  input  logic [mhbl_pkg::INDEX_W-1:0]  first_index_i,
  input  logic [mhbl_pkg::INDEX_W-1:0]  second_index_i,
  input  logic [31:0]                   position_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [mhbl_pkg::HOP_W-1:0]    hop_count_o
);

  localparam int unsigned SW    = $clog2(MAX_POINTS + 1);
  localparam int unsigned IW    = SW > mhbl_pkg::INDEX_W ? SW : mhbl_pkg::INDEX_W;
  localparam int unsigned PA_W  = $clog2(MAX_POINTS);
  localparam int unsigned JD    = MAX_POINTS * MAX_LEVELS;
  localparam int unsigned JA_W  = JD > 1 ? $clog2(JD) : 1;
  localparam int unsigned LVW   = MAX_LEVELS > 1 ? $clog2(MAX_LEVELS) : 1;
  localparam int unsigned CNT_W = MAX_LEVELS + 1;
  localparam int unsigned CW    = POS_WIDTH > 32 ? POS_WIDTH : 32;
  localparam int unsigned HW    = mhbl_pkg::HOP_W;

  mhbl_pkg::state_e state_q, state_d;

  logic [mhbl_pkg::COUNT_W-1:0] point_count_q;
  logic [mhbl_pkg::REACH_W-1:0] reach_q;
  logic [LVW-1:0]               top_q, top_d;
  logic [SW-1:0]                built_q, built_d;
  logic [SW-1:0]                lo_q, lo_d, hi_q, hi_d, j_q, j_d;
  logic [LVW-1:0]               lvl_q, lvl_d;
  logic [POS_WIDTH-1:0]         a_q, a_d;
  logic [SW-1:0]                cur_q, cur_d, b_q, b_d;
  logic [CNT_W-1:0]             c_q, c_d, best_q, best_d;
  logic                         out_valid_q, out_valid_d;
  logic [HW-1:0]                hop_q, hop_d;

  logic                 pos_we;
  logic [PA_W-1:0]      pos_waddr, pos_raddr;
  logic [POS_WIDTH-1:0] pos_wdata, pos_rdata;
  logic                 jt_we;
  logic [JA_W-1:0]      jt_waddr, jt_raddr;
  logic [SW-1:0]        jt_wdata, jt_rdata;

  logic             in_acc, out_free, in_reach, take;
  logic [SW-1:0]    n_eff, qa, qb, qlo, qhi, cur_nx;
  logic [IW-1:0]    pc_w, fi_w;
  logic [CNT_W-1:0] step, cand;
  logic [CW-1:0]    a_ext, b_ext;

  function automatic logic [LVW-1:0] top_of(input logic [SW-1:0] n);
    logic [SW-1:0] m;
    int unsigned   k;
    m = n - 1'b1;
    k = 0;
    for (int i = 1; i < SW; i++) begin
      if (m[i]) k = i;
    end
    if (k > MAX_LEVELS - 1) k = MAX_LEVELS - 1;
    return LVW'(k);
  endfunction

  function automatic logic [SW-1:0] clamp_slot(input logic [mhbl_pkg::INDEX_W-1:0] x,
                                               input logic [SW-1:0] n);
    logic [IW-1:0] xw;
    xw = IW'(x);
    if (xw == '0) return SW'(1);
    if (xw > IW'(n)) return n;
    return SW'(xw);
  endfunction

  function automatic logic [JA_W-1:0] jt_addr(input logic [SW-1:0] slot,
                                              input logic [LVW-1:0] lvl);
    return JA_W'(JA_W'(lvl) * JA_W'(MAX_POINTS) + JA_W'(slot) - JA_W'(1));
  endfunction

  mhbl_ram #(.WIDTH(POS_WIDTH), .DEPTH(MAX_POINTS)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (pos_waddr),
    .wdata_i (pos_wdata),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rdata)
  );

  mhbl_ram #(.WIDTH(SW), .DEPTH(JD)) u_jt_ram (
    .clk_i   (clk_i),
    .we_i    (jt_we),
    .waddr_i (jt_waddr),
    .wdata_i (jt_wdata),
    .raddr_i (jt_raddr),
    .rdata_o (jt_rdata)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != mhbl_pkg::S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign hop_count_o = hop_q;

  // clamped slot count and query endpoints
  assign pc_w  = IW'(point_count_q);
  assign n_eff = (pc_w < IW'(2)) ? SW'(2) :
                 (pc_w > IW'(MAX_POINTS)) ? SW'(MAX_POINTS) : SW'(pc_w);
  assign fi_w  = IW'(first_index_i);
  assign qa    = clamp_slot(first_index_i, built_q);
  assign qb    = clamp_slot(second_index_i, built_q);
  assign qlo   = (qa > qb) ? qb : qa;
  assign qhi   = (qa > qb) ? qa : qb;

  // a position not above the sweep start counts as within reach
  assign a_ext    = CW'(a_q);
  assign b_ext    = CW'(pos_rdata);
  assign in_reach = (b_ext <= a_ext) || ((b_ext - a_ext) <= CW'(reach_q));

  assign step   = CNT_W'(1) << lvl_q;
  assign cand   = c_q + step;
  assign take   = b_q > jt_rdata;
  assign cur_nx = take ? jt_rdata : cur_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mhbl_pkg::S_IDLE: begin
        if (in_acc) begin
          if (mode_i == mhbl_pkg::MODE_BUILD) state_d = mhbl_pkg::S_SW_A;
          else if (mode_i == mhbl_pkg::MODE_QUERY) state_d = mhbl_pkg::S_Q_WALK;
        end
      end
      mhbl_pkg::S_SW_A: state_d = mhbl_pkg::S_SW_B;
      mhbl_pkg::S_SW_B: state_d = mhbl_pkg::S_SW_C;
      mhbl_pkg::S_SW_C: begin
        if (!in_reach) state_d = mhbl_pkg::S_SW_A;
        else if (SW'(hi_q + 1'b1) == built_q) state_d = mhbl_pkg::S_FILL;
        else state_d = mhbl_pkg::S_SW_B;
      end
      mhbl_pkg::S_FILL: begin
        if (lo_q == built_q) begin
          state_d = (top_q == '0) ? mhbl_pkg::S_IDLE : mhbl_pkg::S_DBL_A;
        end
      end
      mhbl_pkg::S_DBL_A: state_d = mhbl_pkg::S_DBL_B;
      mhbl_pkg::S_DBL_B: state_d = mhbl_pkg::S_DBL_C;
      mhbl_pkg::S_DBL_C: begin
        if (j_q == built_q && lvl_q == top_q) state_d = mhbl_pkg::S_IDLE;
        else state_d = mhbl_pkg::S_DBL_A;
      end
      mhbl_pkg::S_Q_WALK: begin
        if (lvl_q == '0) state_d = mhbl_pkg::S_Q_OUT;
      end
      mhbl_pkg::S_Q_OUT: begin
        if (out_free) state_d = mhbl_pkg::S_IDLE;
      end
      default: state_d = mhbl_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    top_d       = top_q;
    built_d     = built_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    j_d         = j_q;
    lvl_d       = lvl_q;
    a_d         = a_q;
    cur_d       = cur_q;
    b_d         = b_q;
    c_d         = c_q;
    best_d      = best_q;
    hop_d       = hop_q;
    out_valid_d = out_valid_q && out_stall_i;
    pos_we      = 1'b0;
    pos_waddr   = PA_W'(fi_w - IW'(1));
    pos_wdata   = POS_WIDTH'(position_i);
    pos_raddr   = PA_W'(lo_q - 1'b1);
    jt_we       = 1'b0;
    jt_waddr    = jt_addr(lo_q, '0);
    jt_wdata    = hi_q;
    jt_raddr    = jt_addr(j_q, LVW'(lvl_q - 1'b1));
    unique case (state_q)
      mhbl_pkg::S_IDLE: begin
        if (in_acc) begin
          case (mode_i)
            mhbl_pkg::MODE_LOAD: begin
              pos_we = (fi_w != '0) && (fi_w <= IW'(MAX_POINTS));
            end
            mhbl_pkg::MODE_BUILD: begin
              built_d = n_eff;
              top_d   = top_of(n_eff);
              lo_d    = SW'(1);
              hi_d    = SW'(1);
            end
            mhbl_pkg::MODE_QUERY: begin
              cur_d    = qlo;
              b_d      = qhi;
              lvl_d    = top_q;
              c_d      = '0;
              best_d   = '1;
              jt_raddr = jt_addr(qlo, top_q);
            end
            default: ;
          endcase
        end
      end
      mhbl_pkg::S_SW_A: pos_raddr = PA_W'(lo_q - 1'b1);
      mhbl_pkg::S_SW_B: begin
        a_d       = pos_rdata;
        pos_raddr = PA_W'(hi_q);
      end
      mhbl_pkg::S_SW_C: begin
        if (in_reach) begin
          hi_d = SW'(hi_q + 1'b1);
        end else begin
          jt_we    = 1'b1;
          jt_waddr = jt_addr(lo_q, '0);
          jt_wdata = hi_q;
          lo_d     = SW'(lo_q + 1'b1);
        end
      end
      mhbl_pkg::S_FILL: begin
        // slots from the last sweep start onward reach the end in one hop
        jt_we    = 1'b1;
        jt_waddr = jt_addr(lo_q, '0);
        jt_wdata = built_q;
        lo_d     = SW'(lo_q + 1'b1);
        lvl_d    = LVW'(1);
        j_d      = SW'(1);
      end
      mhbl_pkg::S_DBL_A: jt_raddr = jt_addr(j_q, LVW'(lvl_q - 1'b1));
      mhbl_pkg::S_DBL_B: jt_raddr = jt_addr(jt_rdata, LVW'(lvl_q - 1'b1));
      mhbl_pkg::S_DBL_C: begin
        jt_we    = 1'b1;
        jt_waddr = jt_addr(j_q, lvl_q);
        jt_wdata = jt_rdata;
        if (j_q == built_q) begin
          j_d   = SW'(1);
          lvl_d = LVW'(lvl_q + 1'b1);
        end else begin
          j_d = SW'(j_q + 1'b1);
        end
      end
      mhbl_pkg::S_Q_WALK: begin
        if (take) begin
          cur_d = jt_rdata;
          c_d   = cand;
        end else if (cand < best_q) begin
          best_d = cand;
        end
        if (lvl_q != '0) begin
          lvl_d    = LVW'(lvl_q - 1'b1);
          jt_raddr = jt_addr(cur_nx, LVW'(lvl_q - 1'b1));
        end
      end
      mhbl_pkg::S_Q_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          hop_d = (32'(best_q) > 32'(mhbl_pkg::HOP_MAX)) ? mhbl_pkg::HOP_MAX : HW'(best_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= mhbl_pkg::S_IDLE;
      out_valid_q   <= 1'b0;
      point_count_q <= mhbl_pkg::POINT_COUNT_RESET;
      reach_q       <= mhbl_pkg::REACH_RESET;
      top_q         <= '0;
      built_q       <= SW'(2);
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      top_q       <= top_d;
      built_q     <= built_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          mhbl_pkg::CFG_POINT_COUNT: point_count_q <= cfg_data_i[mhbl_pkg::COUNT_W-1:0];
          mhbl_pkg::CFG_REACH_LIMIT: reach_q <= cfg_data_i[mhbl_pkg::REACH_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    j_q    <= j_d;
    lvl_q  <= lvl_d;
    a_q    <= a_d;
    cur_q  <= cur_d;
    b_q    <= b_d;
    c_q    <= c_d;
    best_q <= best_d;
    hop_q  <= hop_d;
  end

endmodule

FILE: rtl/mhbl_ram.sv
// ----------------------------------------------------------------------------
// mhbl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mhbl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
